### rtl/spectrum_bin_level_peak_hold_macros.svh
// ---------------------------------------------------------------------------
// Spectrum bin level meter: assertion macros
// Shared concurrent assertion forms for the level meter blocks.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_BIN_LEVEL_PEAK_HOLD_MACROS_SVH
`define SPECTRUM_BIN_LEVEL_PEAK_HOLD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SBLPH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SBLPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sblph_pkg.sv
// ---------------------------------------------------------------------------
// Spectrum bin level meter package
// Constants, register codes and the level mapping shared by the block.
// ---------------------------------------------------------------------------
package sblph_pkg;

  localparam int NUM_BINS_DEF = 32;

  localparam int PEAK_W  = 4;
  localparam int MAG_W   = 7;
  localparam int SUM_W   = 16;
  localparam int SQRT_W  = 8;
  localparam int ROOT_W  = 10;
  localparam int REM_W   = 12;
  localparam int STEP_W  = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

  localparam logic [3:0] MAX_LEVEL   = 4'd8;
  localparam logic [6:0] MAG_MAX     = 7'd127;
  localparam logic [3:0] DROOP_RESET = 4'd5;

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_LINEAR_MODE  = 1'b0,
    REG_DROOP_PERIOD = 1'b1
  } reg_idx_t;

  // The level table is 0..8 with a top entry, so it yields min(m, 8); the
  // level then saturates at eight.
  function automatic logic [3:0] bar_level_of(logic [MAG_W-1:0] mag, logic linear);
    logic [4:0] t;
    logic [4:0] lv;
    t  = mag[6:2];
    lv = t - (t >> 1);
    if (linear) begin
      return (lv > 5'(MAX_LEVEL)) ? MAX_LEVEL : lv[3:0];
    end
    return (mag > 7'(MAX_LEVEL)) ? MAX_LEVEL : mag[3:0];
  endfunction

endpackage

### rtl/sblph_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module sblph_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/sblph_isqrt.sv
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 16-bit operand, two operand bits per cycle.
// ---------------------------------------------------------------------------
module sblph_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sblph_pkg::SUM_W-1:0] operand,
  output logic                        busy,
  output logic [sblph_pkg::SQRT_W-1:0] root
);
  import sblph_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  a_r, a_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  logic [ROOT_W-1:0] root2;
  logic [ROOT_W-1:0] trial;
  logic [REM_W-1:0]  rem2;

  always_comb begin
    root2    = {root_r[ROOT_W-2:0], 1'b0};
    rem2     = {rem_r[REM_W-3:0], a_r[SUM_W-1:SUM_W-2]};
    trial    = root2 + 1'b1;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = operand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      a_nxt   = {a_r[SUM_W-3:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (REM_W'(trial) <= rem2) begin
        rem_nxt  = rem2 - REM_W'(trial);
        root_nxt = trial + 1'b1;
      end else begin
        rem_nxt  = rem2;
        root_nxt = root2;
      end
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r    <= a_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r[SQRT_W:1];

endmodule

### rtl/spectrum_bin_level_peak_hold.sv
// ---------------------------------------------------------------------------
// Spectrum bin level meter with peak hold
// Magnitude, bar level and per-bin peak-hold dot for one spectrum bin.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_ready  bin_real, bin_imag, bin_index, frame_end
//  out_     output     out_valid/out_ready  bar_level, peak_level, magnitude
//  cfg      input      APB psel/penable     linear_mode at 0x0, droop_period at 0x4
//
// An item is accepted in idle, which loads the root unit and starts the peak read.
// Eight root iterations follow, then the block moves to the result state, which
// commits the peak store and the result once the output register is free.
// The block then returns to idle, where it takes the next item.
// The iterative square root sets the pace; one item is in work at a time.
// Reset clears the valid bits of the peak store, so all entries read as zero.
// A result waiting on out_ready does not block the next item until its update.
// ---------------------------------------------------------------------------
module spectrum_bin_level_peak_hold #(
  parameter int NUM_BINS = sblph_pkg::NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [7:0]             in_bin_real,
  input  logic signed [7:0]             in_bin_imag,
  input  logic [4:0]                    in_bin_index,
  input  logic                          in_frame_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [3:0]                    out_bar_level,
  output logic [3:0]                    out_peak_level,
  output logic [6:0]                    out_magnitude,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sblph_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sblph_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROOT = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic              linear_mode_r;
  logic [3:0]        droop_period_r;
  logic [3:0]        droop_r;
  logic [ADDR_W-1:0] addr_r;
  logic              in_range_r;
  logic              frame_end_r;
  logic [NUM_BINS-1:0] valid_r;

  logic              out_valid_r;
  logic [3:0]        out_bar_r;
  logic [3:0]        out_peak_r;
  logic [MAG_W-1:0]  out_mag_r;

  logic              in_accept;
  logic              cfg_write;
  logic              commit;
  logic              root_busy;
  logic [SQRT_W-1:0] root;
  logic [SUM_W-1:0]  sum;
  logic signed [15:0] re_sq;
  logic signed [15:0] im_sq;
  logic [PEAK_W-1:0] ram_rdata;
  logic [PEAK_W-1:0] peak_old;
  logic [PEAK_W-1:0] peak_new;
  logic [3:0]        level;
  logic [MAG_W-1:0]  mag;
  logic              levels_ok;
  logic              done_stalled;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_LINEAR_MODE:  prdata = {31'b0, linear_mode_r};
      REG_DROOP_PERIOD: prdata = {28'b0, droop_period_r};
      default:          prdata = '0;
    endcase
  end

  assign re_sq = in_bin_real * in_bin_real;
  assign im_sq = in_bin_imag * in_bin_imag;
  assign sum   = SUM_W'(re_sq) + SUM_W'(im_sq);

  sblph_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_accept),
    .operand (sum),
    .busy    (root_busy),
    .root    (root)
  );

  assign commit = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  assign mag      = (root > SQRT_W'(MAG_MAX)) ? MAG_MAX : root[MAG_W-1:0];
  assign level    = bar_level_of(mag, linear_mode_r);
  assign peak_old = (in_range_r && valid_r[addr_r]) ? ram_rdata : '0;

  always_comb begin
    if (level > peak_old) begin
      peak_new = level;
    end else if (droop_r == '0 && peak_old != '0) begin
      peak_new = peak_old - 1'b1;
    end else begin
      peak_new = peak_old;
    end
  end

  sblph_ram #(
    .WIDTH (PEAK_W),
    .DEPTH (NUM_BINS)
  ) u_peak_ram (
    .clk   (clk),
    .we    (commit && in_range_r),
    .waddr (addr_r),
    .wdata (peak_new),
    .re    (in_accept),
    .raddr (ADDR_W'(in_bin_index)),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_accept) begin
        state_nxt = ST_ROOT;
      end
      ST_ROOT: if (!root_busy) begin
        state_nxt = ST_DONE;
      end
      ST_DONE: if (commit) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      linear_mode_r  <= 1'b0;
      droop_period_r <= DROOP_RESET;
      droop_r        <= '0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write) begin
        unique case (reg_idx_t'(paddr[2]))
          REG_LINEAR_MODE:  linear_mode_r  <= pwdata[0];
          REG_DROOP_PERIOD: droop_period_r <= pwdata[3:0];
          default:          linear_mode_r  <= linear_mode_r;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (in_range_r) begin
          valid_r[addr_r] <= 1'b1;
        end
        if (frame_end_r) begin
          droop_r <= (droop_r != '0) ? droop_r - 1'b1 : droop_period_r;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_accept) begin
      addr_r      <= ADDR_W'(in_bin_index);
      in_range_r  <= (int'(in_bin_index) < NUM_BINS);
      frame_end_r <= in_frame_end;
    end
    if (commit) begin
      out_bar_r  <= level;
      out_peak_r <= peak_new;
      out_mag_r  <= mag;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bar_level  = out_bar_r;
  assign out_peak_level = out_peak_r;
  assign out_magnitude  = out_mag_r;

  assign levels_ok    = (out_bar_r <= MAX_LEVEL) && (out_peak_r <= MAX_LEVEL);
  assign done_stalled = (state_r == ST_DONE) && out_valid_r;

`include "spectrum_bin_level_peak_hold_macros.svh"

  `SBLPH_ASSERT_NEXT(a_root_starts, in_accept, root_busy, "Root unit idle after an item")
  `SBLPH_ASSERT_NOW(a_levels_bound, out_valid_r, levels_ok, "Bar or peak out of range")
  `SBLPH_ASSERT_NEXT(a_done_waits, done_stalled && !out_ready, done_stalled, "Stalled result lost")

endmodule

### sim/tb_spectrum_bin_level_peak_hold.sv
// ---------------------------------------------------------------------------
// Spectrum bin level meter testbench
// Sends complex spectrum bins through the level meter under both level
// mappings and several droop periods, predicts magnitude, bar height and
// peak-hold dot for every item, and checks each result in order.
// ---------------------------------------------------------------------------
module tb_spectrum_bin_level_peak_hold;
  import sblph_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 14;
  localparam int RAND_PER_SET = 300;

  typedef struct {
    logic signed [7:0] re;
    logic signed [7:0] im;
    logic [4:0]        idx;
    logic              last;
    bit                hold;
  } bin_item_t;

  typedef struct {
    logic [3:0] bar;
    logic [3:0] peak;
    logic [6:0] mag;
  } bin_levels_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [7:0] in_bin_real = '0;
  logic signed [7:0] in_bin_imag = '0;
  logic [4:0] in_bin_index = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_bar_level;
  logic [3:0] out_peak_level;
  logic [6:0] out_magnitude;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bin_item_t   bins_to_send[$];
  bin_levels_t levels_due[$];
  bin_item_t   in_flight;

  logic [3:0] peak_hold [32];
  logic [3:0] droop_cnt = '0;
  logic       linear_q = 1'b0;
  logic [3:0] droop_period_q = DROOP_RESET;

  bit steady = 1'b0;
  int items_issued = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int fails = 0;
  int settings_run = 1;
  int idle_cycles = 0;

  spectrum_bin_level_peak_hold dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_bin_real(in_bin_real), .in_bin_imag(in_bin_imag),
    .in_bin_index(in_bin_index), .in_frame_end(in_frame_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_bar_level(out_bar_level), .out_peak_level(out_peak_level),
    .out_magnitude(out_magnitude),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < 32; i++) peak_hold[i] = '0;
  end

  // Works out magnitude, bar height and peak dot for one item and advances
  // the peak store and droop counter.
  function automatic void compute_bin_levels(bin_item_t b);
    int re_i, im_i;
    int unsigned power, root, trial;
    logic [6:0] mag;
    logic [4:0] quarter;
    logic [3:0] bar, peak;
    bin_levels_t lv;
    re_i = b.re;
    im_i = b.im;
    power = re_i * re_i + im_i * im_i;
    root = 0;
    for (int k = 7; k >= 0; k--) begin
      trial = root | (1 << k);
      if (trial * trial <= power) root = trial;
    end
    mag = (root > 127) ? MAG_MAX : root[6:0];
    if (linear_q) begin
      quarter = mag[6:2];
      quarter = quarter - (quarter >> 1);
      bar = (quarter > 5'd8) ? MAX_LEVEL : quarter[3:0];
    end else begin
      bar = (mag > 7'd8) ? MAX_LEVEL : mag[3:0];
    end
    peak = peak_hold[b.idx];
    if (bar > peak) peak = bar;
    else if (droop_cnt == 0 && peak != 0) peak = peak - 1'b1;
    peak_hold[b.idx] = peak;
    if (b.last) droop_cnt = (droop_cnt != 0) ? droop_cnt - 1'b1 : droop_period_q;
    lv.bar = bar;
    lv.peak = peak;
    lv.mag = mag;
    levels_due.push_back(lv);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        compute_bin_levels(in_flight);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (bins_to_send.size() > 0 && !(bins_to_send[0].hold && levels_due.size() > 0)
            && (steady || $urandom_range(99) >= 20)) begin
          in_flight = bins_to_send.pop_front();
          in_bin_real  <= in_flight.re;
          in_bin_imag  <= in_flight.im;
          in_bin_index <= in_flight.idx;
          in_frame_end <= in_flight.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 20);
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      fails++;
      if (fails <= 40) $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bin_levels_t want;
    if (rst_n && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        fails++;
        $display("%0t: result with none expected, got bar %0d peak %0d magnitude %0d",
                 $time, out_bar_level, out_peak_level, out_magnitude);
      end else begin
        want = levels_due.pop_front();
        results_seen++;
        check_field("bar_level", want.bar, out_bar_level);
        check_field("peak_level", want.peak, out_peak_level);
        check_field("magnitude", want.mag, out_magnitude);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] value);
    logic [31:0] read_want;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (r == REG_LINEAR_MODE) linear_q = value[0];
    else droop_period_q = value[3:0];
    read_want = (r == REG_LINEAR_MODE) ? {31'd0, value[0]} : {28'd0, value[3:0]};
    @(posedge clk);
    check_field("register readback", read_want, prdata);
  endtask

  task automatic send_bin(int re, int im, int idx, bit last, bit hold = 1'b0);
    bin_item_t b;
    b.re = re[7:0];
    b.im = im[7:0];
    b.idx = idx[4:0];
    b.last = last;
    b.hold = hold;
    bins_to_send.push_back(b);
    items_issued++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_issued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(bit linear, int period);
    write_reg(REG_LINEAR_MODE, {31'd0, linear});
    write_reg(REG_DROOP_PERIOD, period);
    settings_run++;
  endtask

  function automatic int rand_part(int amp);
    int v;
    v = int'($urandom_range(2 * amp)) - amp;
    return (v > 127) ? 127 : v;
  endfunction

  // Mostly frames starting at bin 0 with random strength, some stray bins.
  task automatic send_random_set(int count);
    int sent, nbins, amp, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        nbins = ($urandom_range(3) == 0) ? 32 : $urandom_range(2, 32);
        for (int b = 0; b < nbins; b++) begin
          case ($urandom_range(4))
            0: amp = 2;
            1: amp = 6;
            2: amp = 14;
            3: amp = 45;
            default: amp = 128;
          endcase
          send_bin(rand_part(amp), rand_part(amp), b, b == nbins - 1,
                   b == 0 && $urandom_range(49) == 0);
        end
        sent += nbins;
      end else begin
        send_bin(rand_part(128), rand_part(128), $urandom_range(31),
                 $urandom_range(3) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Level table mapping with the reset droop period.
    send_bin(0, 0, 0, 0);
    send_bin(1, 0, 1, 0);
    send_bin(3, 4, 2, 0);
    send_bin(6, 8, 3, 0);
    send_bin(0, 7, 4, 0);
    send_bin(0, 9, 7, 0);
    send_bin(-128, -128, 31, 1);
    send_bin(127, 127, 30, 0);
    send_bin(-128, 0, 5, 0);
    send_bin(127, -128, 6, 0);
    send_bin(0, 0, 3, 1, 1'b1);
    for (int i = 0; i < 6; i++) send_bin(0, 0, 3, 1);
    wait_drained();

    // Linear mapping with a zero droop period.
    set_mode(1'b1, 0);
    send_bin(4, 0, 8, 0);
    send_bin(8, 0, 9, 0);
    send_bin(12, 0, 10, 0);
    send_bin(63, 0, 11, 0);
    send_bin(-128, -128, 12, 1);
    for (int i = 0; i < 3; i++) send_bin(0, 0, 12, 1);
    wait_drained();

    set_mode(1'b0, 0);
    send_random_set(RAND_PER_SET);
    wait_drained();

    set_mode(1'b1, 15);
    steady = 1'b1;
    send_random_set(RAND_PER_SET);
    wait_drained();
    steady = 1'b0;

    set_mode(1'b0, 15);
    send_random_set(RAND_PER_SET);
    wait_drained();

    set_mode(1'b1, 3);
    send_random_set(RAND_PER_SET);
    wait_drained();

    set_mode(1'b0, 1);
    send_random_set(RAND_PER_SET);
    wait_drained();

    set_mode(1'b1, 0);
    send_random_set(RAND_PER_SET);
    wait_drained();

    if (levels_due.size() != 0) begin
      fails++;
      $display("%0t: %0d results never arrived", $time, levels_due.size());
    end
    $display("Sent %0d bins and checked %0d results under %0d register settings,",
             items_accepted, results_seen, settings_run);
    $display("covering table and linear mapping and droop periods from 0 to 15.");
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
